// ===== hdl/sliding_window_maximum_top_assert.svh =====
`ifndef SLIDING_WINDOW_MAXIMUM_TOP_ASSERT_SVH
`define SLIDING_WINDOW_MAXIMUM_TOP_ASSERT_SVH

// condition that must hold at every clock edge out of reset
`define SWM_ASSERT_ALWAYS(label, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("sliding window maximum: invariant broken");

// condition that must hold in the same cycle as its trigger
`define SWM_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sliding window maximum: implication broken");

// condition that must hold in the cycle after its trigger
`define SWM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sliding window maximum: next-cycle check broken");

`endif

// ===== hdl/swm_pkg.sv =====
package swm_pkg;

  localparam int SAMPLE_W = 32;
  localparam int CFG_W    = 7;
  localparam logic [CFG_W-1:0] WS_RESET = 7'd3;

  // one queue slot or one select-tree node
  typedef struct packed {
    logic                       found;
    logic signed [SAMPLE_W-1:0] value;
  } node_t;

  // control shared by every cell of the chain
  typedef struct packed {
    logic shift;
    logic restart;
  } cell_ctl_t;

  // item bookkeeping travelling beside the select tree
  typedef struct packed {
    logic valid;
    logic emit;
    logic last;
  } tag_t;

  // one result waiting in the output queue
  typedef struct packed {
    logic [SAMPLE_W-1:0] window_max;
    logic                final_window;
  } result_t;

endpackage

// ===== hdl/swm_cell.sv =====
module swm_cell (
  input  logic                               clk,
  input  logic                               rst,
  input  swm_pkg::cell_ctl_t                 ctl,
  input  logic                               head,
  input  logic                               keep,
  input  logic signed [swm_pkg::SAMPLE_W-1:0] sample,
  input  swm_pkg::node_t                     prev,
  output swm_pkg::node_t                     cur
);

  logic                               alive;
  logic signed [swm_pkg::SAMPLE_W-1:0] value;

  // survives if in the window, no restart and above the new sample
  always_ff @(posedge clk) begin
    if (rst) begin
      alive <= 1'b0;
    end else if (ctl.shift) begin
      alive <= prev.found && keep &&
               (head || (!ctl.restart && ($signed(prev.value) > sample)));
    end
  end

  // value moves one place older on every item
  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      value <= prev.value;
    end
  end

  assign cur = '{found: alive, value: value};

endmodule

// ===== hdl/swm_node.sv =====
module swm_node (
  input  logic           clk,
  input  swm_pkg::node_t younger,
  input  swm_pkg::node_t older,
  output swm_pkg::node_t sel
);

  // keep the oldest live entry of the pair
  always_ff @(posedge clk) begin
    sel <= older.found ? older : younger;
  end

endmodule

// ===== hdl/sliding_window_maximum_top.sv =====
// result path: cell chain, select tree of L levels, output queue; L = ceil(log2(WINDOW_MAX)), min 1
// throughput: one item per cycle while s_tready is high; each item shifts the cell chain once and the
//   registered select tree (L levels) finds the oldest live cell behind it
// an output queue of L+3 results with credit counting keeps the pipeline moving
// reset: clears the chain, fill count, item tags and output queue; window_size = 3
module sliding_window_maximum_top #(
  parameter int WINDOW_MAX = 64
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_wr_en,
  input  logic [swm_pkg::CFG_W-1:0]     cfg_wr_data,  // window_size
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [swm_pkg::SAMPLE_W-1:0]  s_tdata,      // [31:0] sample
  input  logic [0:0]                    s_tuser,      // [0] restart
  input  logic                          s_tlast,      // end_of_sequence
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [swm_pkg::SAMPLE_W-1:0]  m_tdata,      // [31:0] window_max
  output logic                          m_tlast       // final_window
);

  localparam int L  = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int P  = 2 ** L;
  localparam int CW = $clog2(WINDOW_MAX + 1);
  localparam int SW = (CW > swm_pkg::CFG_W) ? CW : swm_pkg::CFG_W;
  localparam int D  = L + 3;
  localparam int DW = $clog2(D);
  localparam int QW = $clog2(D + 1);

  logic [swm_pkg::CFG_W-1:0] window_size;
  logic [CW-1:0]             fill;
  logic [CW-1:0]             fill_next;
  logic [SW-1:0]             ws_ext;
  logic [SW-1:0]             k_eff;
  logic                      accept;
  logic                      restart;
  logic [WINDOW_MAX-1:0]     keep;
  swm_pkg::cell_ctl_t        ctl;
  swm_pkg::node_t            chain [WINDOW_MAX];
  swm_pkg::node_t            tree  [1:2*P-1];
  swm_pkg::node_t            head_in;
  swm_pkg::tag_t             tags  [0:L];
  swm_pkg::result_t          q     [D];
  logic [DW-1:0]             wr_ptr;
  logic [DW-1:0]             rd_ptr;
  logic [QW-1:0]             q_cnt;
  logic [QW-1:0]             q_cnt_next;
  logic [QW-1:0]             credit;
  logic [QW-1:0]             credit_next;
  logic                      push;
  logic                      pop;
  logic                      drop;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      window_size <= swm_pkg::WS_RESET;
    end else if (cfg_wr_en) begin
      window_size <= cfg_wr_data;
    end
  end

  // window size clamped to 1..WINDOW_MAX
  always_comb begin
    ws_ext = SW'(window_size);
    if (window_size == '0) begin
      k_eff = SW'(1);
    end else if (ws_ext > SW'(WINDOW_MAX)) begin
      k_eff = SW'(WINDOW_MAX);
    end else begin
      k_eff = ws_ext;
    end
  end

  assign accept  = s_tvalid && s_tready;
  assign restart = s_tuser[0];
  assign ctl     = '{shift: accept, restart: restart};
  assign head_in = '{found: 1'b1, value: $signed(s_tdata)};

  // samples seen in the current sequence, saturating
  always_comb begin
    if (restart) begin
      fill_next = CW'(1);
    end else if (fill == CW'(WINDOW_MAX)) begin
      fill_next = fill;
    end else begin
      fill_next = fill + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
    end else if (accept) begin
      fill <= fill_next;
    end
  end

  // chain of cells, cell i holds the sample of age i
  for (genvar i = 0; i < WINDOW_MAX; i++) begin : g_cell
    assign keep[i] = SW'(i) < k_eff;
    if (i == 0) begin : g_head
      swm_cell u_cell (
        .clk(clk), .rst(rst), .ctl(ctl), .head(1'b1), .keep(keep[i]),
        .sample($signed(s_tdata)), .prev(head_in), .cur(chain[i])
      );
    end else begin : g_body
      swm_cell u_cell (
        .clk(clk), .rst(rst), .ctl(ctl), .head(1'b0), .keep(keep[i]),
        .sample($signed(s_tdata)), .prev(chain[i-1]), .cur(chain[i])
      );
    end
  end

  // tree leaves, unused ones never match
  for (genvar i = 0; i < P; i++) begin : g_leaf
    if (i < WINDOW_MAX) begin : g_used
      assign tree[P+i] = chain[i];
    end else begin : g_pad
      assign tree[P+i] = '0;
    end
  end

  // registered select tree for the oldest live cell (the queue front)
  for (genvar j = 1; j < P; j++) begin : g_node
    swm_node u_node (
      .clk(clk), .younger(tree[2*j]), .older(tree[2*j+1]), .sel(tree[j])
    );
  end

  // item tags follow the tree, one stage per level
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int t = 0; t <= L; t++) begin
        tags[t] <= '0;
      end
    end else begin
      tags[0] <= '{valid: accept, emit: SW'(fill_next) >= k_eff, last: s_tlast};
      for (int t = 1; t <= L; t++) begin
        tags[t] <= tags[t-1];
      end
    end
  end

  assign push = tags[L].valid && tags[L].emit;
  assign drop = tags[L].valid && !tags[L].emit;
  assign pop  = m_tvalid && m_tready;

  // output queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= '{window_max: tree[1].value, final_window: tags[L].last};
    end
  end

  // output queue pointers and counts
  always_comb begin
    q_cnt_next  = q_cnt + QW'(push) - QW'(pop);
    credit_next = credit + QW'(accept) - QW'(drop) - QW'(pop);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      q_cnt  <= '0;
      credit <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == DW'(D - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == DW'(D - 1)) ? '0 : rd_ptr + 1'b1;
      end
      q_cnt  <= q_cnt_next;
      credit <= credit_next;
    end
  end

  assign s_tready = credit < QW'(D);
  assign m_tvalid = q_cnt != '0;
  assign m_tdata  = q[rd_ptr].window_max;
  assign m_tlast  = q[rd_ptr].final_window;

  `include "sliding_window_maximum_top_assert.svh"

  // outstanding items never exceed the queue room
  `SWM_ASSERT_ALWAYS(a_credit_bound, (credit <= QW'(D)) && (q_cnt <= credit))
  // a result is never pushed into a full queue
  `SWM_ASSERT_IMPL(a_no_overflow, push, q_cnt < QW'(D))
  // the newest sample is always live after an accept
  `SWM_ASSERT_NEXT(a_head_alive, accept, chain[0].found)
  // the tree always finds a front for an item leaving it
  `SWM_ASSERT_IMPL(a_front_found, tags[L].valid, tree[1].found)

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;

  localparam int WIN_LIMIT      = 64;
  localparam int SETTLE_CYCLES  = 16;
  localparam int STALL_CYCLES   = 300;
  localparam int WATCHDOG_LIMIT = 2000;

  logic                         clk = 1'b0;
  logic                         rst = 1'b1;
  logic                         cfg_wr_en = 1'b0;
  logic [swm_pkg::CFG_W-1:0]    cfg_wr_data = '0;
  logic                         s_tvalid = 1'b0;
  logic                         s_tready;
  logic [swm_pkg::SAMPLE_W-1:0] s_tdata = '0;   // [31:0] sample
  logic [0:0]                   s_tuser = '0;   // [0] restart
  logic                         s_tlast = 1'b0; // end_of_sequence
  logic                         m_tvalid;
  logic                         m_tready = 1'b0;
  logic [swm_pkg::SAMPLE_W-1:0] m_tdata;        // [31:0] window_max
  logic                         m_tlast;        // final_window

  // idling odds in percent, long receiver stall request
  int unsigned snd_idle_pct = 0;
  int unsigned rcv_idle_pct = 0;
  logic        stall_req = 1'b0;
  int          stall_cnt;

  // predictor state: decreasing run of recent samples with their ages
  logic signed [31:0]      mono_val[$];
  int unsigned             mono_age[$];
  int unsigned             seq_fill = 0;
  logic [swm_pkg::CFG_W-1:0] win_size = swm_pkg::WS_RESET;
  swm_pkg::result_t        pending_max_q[$];

  int mismatches = 0;
  int idle_cycles = 0;

  sliding_window_maximum_top #(
    .WINDOW_MAX(WIN_LIMIT)
  ) i_dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .s_tlast    (s_tlast),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tlast    (m_tlast)
  );

  // clock
  initial begin
    forever #5 clk = ~clk;
  end

  // expected window maximum for one accepted sample
  function automatic void track_window_max(input logic signed [31:0] smp, input bit rs,
                                           input bit eos);
    int unsigned k;
    swm_pkg::result_t res;
    k = 32'(win_size);
    if (k < 1) k = 1;
    if (k > WIN_LIMIT) k = WIN_LIMIT;
    if (rs) begin
      mono_val.delete();
      mono_age.delete();
      seq_fill = 0;
    end
    foreach (mono_age[i]) mono_age[i]++;
    // expired entries sit at the front
    while (mono_age.size() > 0 && mono_age[0] >= k) begin
      void'(mono_val.pop_front());
      void'(mono_age.pop_front());
    end
    // smaller or equal entries can never be the maximum again
    while (mono_val.size() > 0 && mono_val[$] <= smp) begin
      void'(mono_val.pop_back());
      void'(mono_age.pop_back());
    end
    if (mono_val.size() >= WIN_LIMIT) begin
      void'(mono_val.pop_front());
      void'(mono_age.pop_front());
    end
    mono_val.push_back(smp);
    mono_age.push_back(0);
    if (seq_fill < WIN_LIMIT) seq_fill++;
    if (seq_fill >= k) begin
      res.window_max   = mono_val[0];
      res.final_window = eos;
      pending_max_q.push_back(res);
    end
  endfunction

  // offer one sample, wait for acceptance, then predict
  task automatic send_sample(input logic [31:0] smp, input bit rs, input bit eos);
    while ($urandom_range(99) < snd_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= smp;
    s_tuser  <= rs;
    s_tlast  <= eos;
    do @(posedge clk); while (!s_tready);
    track_window_max(smp, rs, eos);
  endtask

  // wait until every expected result is out and the pipeline is empty
  task automatic drain_results();
    s_tvalid <= 1'b0;
    while (pending_max_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_window_size(input logic [swm_pkg::CFG_W-1:0] ws);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= ws;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    win_size = ws;
  endtask

  // one run of samples in a random style
  task automatic send_sequence(input int len, input bit with_restart, input bit with_end);
    int          style;
    int          i;
    logic [31:0] smp;
    logic [31:0] ramp;
    logic [31:0] step;
    bit          rs;
    bit          eos;
    style = $urandom_range(4);
    ramp  = $urandom();
    step  = $urandom_range(1000, 1);
    if ($urandom_range(1)) step = -step;
    for (i = 0; i < len; i++) begin
      case (style)
        0: smp = $urandom();
        1: smp = $urandom_range(6) - 3;
        2: begin
          case ($urandom_range(4))
            0: smp = 32'h8000_0000;
            1: smp = 32'h7fff_ffff;
            2: smp = 32'h0000_0000;
            3: smp = 32'hffff_ffff;
            default: smp = 32'h0000_0001;
          endcase
        end
        3: begin
          smp  = ramp;
          ramp = ramp + step;
        end
        default: smp = $urandom_range(1) ? $urandom() : $urandom_range(6) - 3;
      endcase
      rs  = (i == 0) ? with_restart : ($urandom_range(99) < 3);
      eos = (i == len - 1) ? with_end : ($urandom_range(99) < 3);
      send_sample(smp, rs, eos);
    end
  endtask

  // default window of three: short run, end before the window fills, run past the end
  task automatic test_short_sequences();
    send_sample(32'h8000_0000, 1'b1, 1'b0);
    send_sample(32'h7fff_ffff, 1'b0, 1'b1);
    send_sample(32'h0000_0000, 1'b0, 1'b0);
    send_sample(32'hffff_ffff, 1'b0, 1'b0);
    send_sample(32'h0000_0001, 1'b0, 1'b0);
    send_sample(32'd5, 1'b1, 1'b0);
    send_sample(32'd5, 1'b0, 1'b0);
    send_sample(32'd9, 1'b0, 1'b0);
    send_sample(32'd8, 1'b0, 1'b0);
    send_sample(32'd7, 1'b0, 1'b0);
    send_sample(32'd6, 1'b0, 1'b1);
  endtask

  // window sizes zero and above the limit, then changes in mid sequence
  task automatic test_window_limits();
    drain_results();
    write_window_size(7'd0);
    send_sample(32'h8000_0000, 1'b1, 1'b1);
    send_sample(32'd7, 1'b0, 1'b0);
    send_sample(32'h7fff_ffff, 1'b0, 1'b1);
    drain_results();
    write_window_size(7'd127);
    send_sample(32'd1, 1'b1, 1'b0);
    send_sample(32'd2, 1'b0, 1'b1);
    drain_results();
    write_window_size(7'd2);
    send_sample(32'd3, 1'b0, 1'b0);
    send_sample(32'hffff_fffd, 1'b0, 1'b1);
    drain_results();
    write_window_size(7'd5);
    send_sample(32'd0, 1'b0, 1'b0);
    send_sample(32'd0, 1'b0, 1'b1);
  endtask

  // receiver holds off while a full window of falling samples streams in
  task automatic test_output_stall();
    logic [31:0] base;
    int          i;
    drain_results();
    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    write_window_size(7'd64);
    stall_req <= 1'b1;
    base = $urandom();
    for (i = 0; i < 100; i++) send_sample(base - i, i == 0, i == 99);
  endtask

  // random runs with random window sizes
  task automatic test_random_stream(input int n_items, input int snd_pct, input int rcv_pct);
    int                      sent;
    int                      r;
    int                      kk;
    int                      len;
    logic [swm_pkg::CFG_W-1:0] ws;
    snd_idle_pct = snd_pct;
    rcv_idle_pct = rcv_pct;
    sent = 0;
    while (sent < n_items) begin
      r = $urandom_range(99);
      if (r < 70) ws = 7'($urandom_range(8, 1));
      else if (r < 85) ws = 7'($urandom_range(64, 9));
      else if (r < 92) ws = 7'($urandom_range(127, 65));
      else if (r < 96) ws = 7'd0;
      else ws = 7'd64;
      if ($urandom_range(9) != 0) begin
        drain_results();
        write_window_size(ws);
      end
      kk = 32'(win_size);
      if (kk < 1) kk = 1;
      if (kk > WIN_LIMIT) kk = WIN_LIMIT;
      if (kk <= 8) len = $urandom_range(kk + 30, 1);
      else len = $urandom_range(kk + 16, kk / 2);
      send_sequence(len, $urandom_range(9) != 0, $urandom_range(9) != 0);
      sent += len;
    end
  endtask

  // receiver: random ready, or a long hold when asked
  initial begin
    forever begin
      @(posedge clk);
      if (rst) begin
        m_tready <= 1'b0;
      end else if (stall_req) begin
        stall_req <= 1'b0;
        m_tready  <= 1'b0;
        for (stall_cnt = 0; stall_cnt < STALL_CYCLES; stall_cnt++) @(posedge clk);
      end else begin
        m_tready <= ($urandom_range(99) >= rcv_idle_pct);
      end
    end
  end

  // compare each result item with the oldest expectation
  always @(posedge clk) begin
    swm_pkg::result_t exp_res;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_max_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual max %h last %b",
                 $time, m_tdata, m_tlast);
        mismatches++;
      end else begin
        exp_res = pending_max_q.pop_front();
        if (m_tdata !== exp_res.window_max) begin
          $display("%0t: window_max mismatch, expected %h, actual %h",
                   $time, exp_res.window_max, m_tdata);
          mismatches++;
        end
        if (m_tlast !== exp_res.final_window) begin
          $display("%0t: final_window mismatch, expected %b, actual %b",
                   $time, exp_res.final_window, m_tlast);
          mismatches++;
        end
      end
    end
  end

  // watchdog on cycles without any accepted item
  always @(posedge clk) begin
    if ((s_tvalid && s_tready === 1'b1) || (m_tvalid === 1'b1 && m_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("*** FAILED ***");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // test sequence
  initial begin
    snd_idle_pct = 26;
    rcv_idle_pct = 72;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_short_sequences();
    test_window_limits();
    test_random_stream(700, 26, 72);
    test_random_stream(700, 72, 26);
    test_output_stall();
    test_random_stream(600, 0, 0);
    drain_results();
    if (mismatches == 0 && pending_max_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
